/* rtl/dlm_pkg.sv */
`default_nettype none

package dlm_pkg;

	// Handle and link widths; a link carries one extra bit for the empty marker.
	localparam int unsigned MAX_ITEMS = 256;
	localparam int unsigned HANDLE_W  = 8;
	localparam int unsigned LINK_W    = 9;
	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned OP_W      = 4;

	localparam logic [LINK_W-1:0] NONE_H = 9'd256;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_INS_AFTER  = 4'd2,
		OP_INS_BEFORE = 4'd3,
		OP_REMOVE     = 4'd4,
		OP_POP_FRONT  = 4'd5,
		OP_POP_BACK   = 4'd6,
		OP_FRONT      = 4'd7,
		OP_BACK       = 4'd8,
		OP_NEXT       = 4'd9,
		OP_PREV       = 4'd10
	} op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_WR2  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// One write to a link memory.
	typedef struct packed {
		logic                we;
		logic [HANDLE_W-1:0] addr;
		logic [LINK_W-1:0]   data;
	} link_wr_t;

endpackage

`default_nettype wire

/* rtl/dlm_ram.sv */
`default_nettype none

module dlm_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/doubly_linked_list_manager.sv */
// After acceptance, each item passes through ST_CALC, which decides from the links read at
// acceptance and does the first link writes, ST_WR2, which does the second link writes, and
// ST_DONE, which loads the output register. A new item is accepted only in ST_IDLE, once the
// last one is through; a result that the receiver has not taken holds the next one back.
// Asynchronous active-low reset empties the list, clears all membership bits and sets the
// capacity limit to zero; link contents are left as they are and need no clearing pass.
`default_nettype none

module doubly_linked_list_manager
	import dlm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,      // capacity_limit
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // operation[3:0], item_handle[11:4],
	                                         // anchor_handle[19:12], zero fill
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata    // ok[0], result_handle[9:1],
	                                         // member_count[18:10], is_full[19],
	                                         // is_empty[20], zero fill
);

	state_t state_q;

	logic [COUNT_W-1:0]  cap_q;
	logic [COUNT_W-1:0]  count_q;
	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   tail_q;
	logic [MAX_ITEMS-1:0] member_q;

	op_t                 op_q;
	logic [HANDLE_W-1:0] item_q;
	logic                item_mem_q;
	logic                anchor_mem_q;
	logic [LINK_W-1:0]   raddr_q;
	logic                ok_q;
	logic [LINK_W-1:0]   res_q;
	link_wr_t            nx2_q;
	link_wr_t            pv2_q;

	logic                accept;
	op_t                 in_op;
	logic [LINK_W-1:0]   rd_addr;
	logic [LINK_W-1:0]   rd_next;
	logic [LINK_W-1:0]   rd_prev;
	link_wr_t            nx_port;
	link_wr_t            pv_port;

	// Decision outputs of the calculation step.
	logic                ok_c;
	logic [LINK_W-1:0]   res_c;
	link_wr_t            nx1_c;
	link_wr_t            pv1_c;
	link_wr_t            nx2_c;
	link_wr_t            pv2_c;
	logic [LINK_W-1:0]   head_c;
	logic [LINK_W-1:0]   tail_c;
	logic [COUNT_W-1:0]  count_c;
	logic                mem_set_c;
	logic                mem_clr_c;
	logic [HANDLE_W-1:0] mem_idx_c;

	logic                full_now;
	logic                out_free;
	logic                full_out;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign in_op    = op_t'(s_axis_tdata[3:0]);
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Pick the entry whose links the operation needs.
	always_comb begin
		case (in_op)
			OP_PUSH_FRONT, OP_POP_FRONT, OP_FRONT:  rd_addr = head_q;
			OP_PUSH_BACK, OP_POP_BACK, OP_BACK:     rd_addr = tail_q;
			OP_INS_AFTER, OP_INS_BEFORE:            rd_addr = {1'b0, s_axis_tdata[19:12]};
			default:                                rd_addr = {1'b0, s_axis_tdata[11:4]};
		endcase
	end

	// The link memories are written only after the read of the same item is done.
	assign nx_port = (state_q == ST_CALC) ? nx1_c :
	                 (state_q == ST_WR2)  ? nx2_q : '0;
	assign pv_port = (state_q == ST_CALC) ? pv1_c :
	                 (state_q == ST_WR2)  ? pv2_q : '0;

	dlm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ITEMS)) u_next_ram (
		.clk   (clk),
		.we    (nx_port.we),
		.waddr (nx_port.addr),
		.wdata (nx_port.data),
		.raddr (rd_addr[HANDLE_W-1:0]),
		.rdata (rd_next)
	);

	dlm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ITEMS)) u_prev_ram (
		.clk   (clk),
		.we    (pv_port.we),
		.waddr (pv_port.addr),
		.wdata (pv_port.data),
		.raddr (rd_addr[HANDLE_W-1:0]),
		.rdata (rd_prev)
	);

	assign full_now = (cap_q != '0) && (count_q >= cap_q);

	// Decide the operation from the links just read and plan the link writes.
	// Head, tail and the links of a member always name members or none, so only
	// the item and anchor membership bits are looked up.
	always_comb begin
		ok_c      = 1'b0;
		res_c     = NONE_H;
		nx1_c     = '0;
		pv1_c     = '0;
		nx2_c     = '0;
		pv2_c     = '0;
		head_c    = head_q;
		tail_c    = tail_q;
		count_c   = count_q;
		mem_set_c = 1'b0;
		mem_clr_c = 1'b0;
		mem_idx_c = item_q;
		case (op_q)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_AFTER, OP_INS_BEFORE: begin
				if (!item_mem_q && !full_now &&
				    ((op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK) ||
				     anchor_mem_q)) begin
					ok_c      = 1'b1;
					mem_set_c = 1'b1;
					count_c   = count_q + 1'b1;
					nx1_c.we   = 1'b1;
					nx1_c.addr = item_q;
					pv1_c.we   = 1'b1;
					pv1_c.addr = item_q;
					if (((op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK)) &&
					    ((count_q == '0) || head_q[LINK_W-1])) begin
						// First member of an empty list.
						nx1_c.data = NONE_H;
						pv1_c.data = NONE_H;
						head_c     = {1'b0, item_q};
						tail_c     = {1'b0, item_q};
					end else if ((op_q == OP_PUSH_BACK) || (op_q == OP_INS_AFTER)) begin
						// Link after the read entry; its old next follows the new one.
						nx1_c.data = rd_next;
						pv1_c.data = raddr_q;
						nx2_c.we   = 1'b1;
						nx2_c.addr = raddr_q[HANDLE_W-1:0];
						nx2_c.data = {1'b0, item_q};
						if (!rd_next[LINK_W-1]) begin
							pv2_c.we   = 1'b1;
							pv2_c.addr = rd_next[HANDLE_W-1:0];
							pv2_c.data = {1'b0, item_q};
						end else begin
							tail_c = {1'b0, item_q};
						end
					end else begin
						// Link before the read entry; its old prev precedes the new one.
						pv1_c.data = rd_prev;
						nx1_c.data = raddr_q;
						pv2_c.we   = 1'b1;
						pv2_c.addr = raddr_q[HANDLE_W-1:0];
						pv2_c.data = {1'b0, item_q};
						if (!rd_prev[LINK_W-1]) begin
							nx2_c.we   = 1'b1;
							nx2_c.addr = rd_prev[HANDLE_W-1:0];
							nx2_c.data = {1'b0, item_q};
						end else begin
							head_c = {1'b0, item_q};
						end
					end
				end
			end
			OP_REMOVE, OP_POP_FRONT, OP_POP_BACK: begin
				if (!raddr_q[LINK_W-1] && ((op_q != OP_REMOVE) || item_mem_q)) begin
					ok_c      = 1'b1;
					if (op_q != OP_REMOVE) begin
						res_c = raddr_q;
					end
					mem_clr_c = 1'b1;
					mem_idx_c = raddr_q[HANDLE_W-1:0];
					if (count_q != '0) begin
						count_c = count_q - 1'b1;
					end
					if (!rd_prev[LINK_W-1]) begin
						nx1_c.we   = 1'b1;
						nx1_c.addr = rd_prev[HANDLE_W-1:0];
						nx1_c.data = rd_next;
					end else begin
						head_c = rd_next;
					end
					if (!rd_next[LINK_W-1]) begin
						pv1_c.we   = 1'b1;
						pv1_c.addr = rd_next[HANDLE_W-1:0];
						pv1_c.data = rd_prev;
					end else begin
						tail_c = rd_prev;
					end
				end
			end
			OP_FRONT, OP_BACK: begin
				if (!raddr_q[LINK_W-1]) begin
					ok_c  = 1'b1;
					res_c = raddr_q;
				end
			end
			OP_NEXT: begin
				if (item_mem_q && !rd_next[LINK_W-1]) begin
					ok_c  = 1'b1;
					res_c = rd_next;
				end
			end
			OP_PREV: begin
				if (item_mem_q && !rd_prev[LINK_W-1]) begin
					ok_c  = 1'b1;
					res_c = rd_prev;
				end
			end
			default: begin
				ok_c = 1'b1;
			end
		endcase
	end

	assign full_out = (cap_q != '0) && (count_q >= cap_q);

	// Sequencer, list registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cap_q         <= '0;
			count_q       <= '0;
			head_q        <= NONE_H;
			tail_q        <= NONE_H;
			member_q      <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready && !((state_q == ST_DONE) && out_free)) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					count_q <= count_c;
					head_q  <= head_c;
					tail_q  <= tail_c;
					if (mem_set_c) begin
						member_q[mem_idx_c] <= 1'b1;
					end
					if (mem_clr_c) begin
						member_q[mem_idx_c] <= 1'b0;
					end
					state_q <= ST_WR2;
				end
				ST_WR2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields, membership lookups, decisions and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= in_op;
			item_q       <= s_axis_tdata[11:4];
			item_mem_q   <= member_q[s_axis_tdata[11:4]];
			anchor_mem_q <= member_q[s_axis_tdata[19:12]];
			raddr_q      <= rd_addr;
		end
		if (state_q == ST_CALC) begin
			ok_q  <= ok_c;
			res_q <= res_c;
			nx2_q <= nx2_c;
			pv2_q <= pv2_c;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_axis_tdata <= {3'b000, (count_q == '0), full_out, count_q, res_q, ok_q};
		end
	end

endmodule

`default_nettype wire
